>>> rtl/rsp_pkg.sv
package rsp_pkg;

   localparam int MaxDepthDefault = 16;
   localparam logic [29:0] BulkMaxReset = 30'd536870912;
   localparam logic [4:0] NestReset = 5'd16;

   localparam logic [7:0] ChCr    = 8'h0d;
   localparam logic [7:0] ChLf    = 8'h0a;
   localparam logic [7:0] ChPlus  = 8'h2b;
   localparam logic [7:0] ChMinus = 8'h2d;
   localparam logic [7:0] ChColon = 8'h3a;
   localparam logic [7:0] ChDollar = 8'h24;
   localparam logic [7:0] ChStar  = 8'h2a;

   localparam logic CsrBulkMax = 1'b0;
   localparam logic CsrNest    = 1'b1;

   typedef enum logic [3:0] {
      EV_SIMPLE_BYTE = 4'd0,
      EV_ERROR_BYTE  = 4'd1,
      EV_BULK_BYTE   = 4'd2,
      EV_SIMPLE_END  = 4'd3,
      EV_ERROR_END   = 4'd4,
      EV_BULK_END    = 4'd5,
      EV_INTEGER     = 4'd6,
      EV_BULK_NULL   = 4'd7,
      EV_ARRAY_HDR   = 4'd8,
      EV_ARRAY_NULL  = 4'd9,
      EV_PARSE_ERROR = 4'd10
   } event_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_UNKNOWN    = 3'd1,
      ERR_EMPTY      = 3'd2,
      ERR_BAD_NUMBER = 3'd3,
      ERR_NO_CRLF    = 3'd4,
      ERR_TOO_DEEP   = 3'd5,
      ERR_INCOMPLETE = 3'd6
   } error_code_type;

   // One result beat as it travels from the front to the back.
   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     data_byte;
      logic [63:0]    number;
      logic [4:0]     nest_level;
      logic           top_done;
      error_code_type error_code;
      logic           last_of_run;
   } event_type;

endpackage

>>> rtl/rsp_front.sv
module rsp_front #(
   parameter int MAX_DEPTH = rsp_pkg::MaxDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          in_byte,
   input  logic                restart,
   input  logic                end_of_data,
   input  logic [29:0]         bulk_max,
   input  logic [4:0]          nest_max,
   output logic [1:0]          ev_count,
   output rsp_pkg::event_type  ev0,
   output rsp_pkg::event_type  ev1
);

   localparam int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int LimMax = (MAX_DEPTH > 31) ? 31 : MAX_DEPTH;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_LINE    = 5'b00010,
      PH_BULK    = 5'b00100,
      PH_BULK_CR = 5'b01000,
      PH_BULK_LF = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      LK_SIMPLE = 3'd0, LK_ERROR = 3'd1, LK_INT = 3'd2, LK_BULK = 3'd3, LK_ARRAY = 3'd4
   } line_kind_type;

   phase_type     phase_ff, phase_in;
   line_kind_type kind_ff, kind_in;
   logic [63:0]   acc_ff, acc_in;
   logic          neg_ff, neg_in, seen_ff, seen_in, cr_ff, cr_in, fail_ff, fail_in;
   logic [29:0]   bulk_ff, bulk_in;
   logic [4:0]    depth_ff, depth_in;
   logic [31:0]   lvl_ff [MAX_DEPTH];
   logic [31:0]   lvl_wdata;
   logic          lvl_we;
   logic [DW-1:0] lvl_widx;

   // Nonzero-remaining flags, one per level.
   logic [MAX_DEPTH-1:0] more_ff, more_in;

   logic [4:0]  limit;
   logic        is_digit;
   logic [3:0]  dval;

   rsp_pkg::event_type e0, e1;
   logic [1:0] cnt;

   always_comb begin
      limit = nest_max;
      if (limit < 5'd1) limit = 5'd1;
      if (limit > 5'(LimMax)) limit = 5'(LimMax);
   end

   // Helper builders.
   function automatic rsp_pkg::event_type mk(rsp_pkg::event_kind_type k, logic [7:0] b,
                                             logic [63:0] n, logic [4:0] l, logic t,
                                             rsp_pkg::error_code_type c);
      rsp_pkg::event_type e;
      e.kind = k; e.data_byte = b; e.number = n; e.nest_level = l;
      e.top_done = t; e.error_code = c; e.last_of_run = 1'b0;
      return e;
   endfunction

   // Only the highest still-open level gets the decrement: every level above it
   // holds a count of one and closes with this value.
   logic [DW-1:0] dec_idx;
   logic          dec_any;
   logic [4:0]    dec_depth;
   always_comb begin
      dec_idx = '0;
      dec_any = 1'b0;
      dec_depth = 5'd0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if (i < int'(depth_ff) && more_ff[i] && lvl_ff[i] > 32'd1) begin
            dec_idx = DW'(i);
            dec_any = 1'b1;
         end
      end
      // levels above dec_idx all close (their counts are 1)
      dec_depth = dec_any ? (5'(dec_idx) + 5'd1) : 5'd0;
   end

   always_comb begin
      is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
      dval = in_byte[3:0];
   end

   // Decimal step with overflow check: acc*10 + d <= limit.
   logic [63:0] x10;
   logic [67:0] wide;
   logic        ovf;
   logic [7:0]  dbyte;
   always_comb begin
      wide = {4'd0, acc_ff} * 68'd10 + 68'(dval);
      x10 = wide[63:0];
      ovf = neg_ff ? (wide > 68'h08000000000000000) : (wide > 68'h07FFFFFFFFFFFFFFF);
      dbyte = in_byte;
   end

   always_comb begin
      logic [63:0] nval;
      logic is_str;
      phase_in = phase_ff; kind_in = kind_ff; acc_in = acc_ff; neg_in = neg_ff;
      seen_in = seen_ff; cr_in = cr_ff; fail_in = fail_ff; bulk_in = bulk_ff;
      depth_in = depth_ff; more_in = more_ff;
      lvl_we = 1'b0; lvl_widx = '0; lvl_wdata = 32'd0;
      e0 = mk(rsp_pkg::EV_SIMPLE_BYTE, 8'd0, 64'd0, 5'd0, 1'b0, rsp_pkg::ERR_NONE);
      e1 = e0;
      cnt = 2'd0;
      nval = neg_ff ? (64'd0 - acc_ff) : acc_ff;
      is_str = (kind_ff == LK_SIMPLE) || (kind_ff == LK_ERROR);
      if (restart) begin
         phase_in = PH_IDLE; kind_in = LK_SIMPLE; acc_in = '0; neg_in = 1'b0;
         seen_in = 1'b0; cr_in = 1'b0; fail_in = 1'b0; bulk_in = '0;
         depth_in = '0; more_in = '0;
      end else if (fail_ff) begin
         cnt = 2'd0;
      end else if (end_of_data) begin
         if (phase_ff != PH_IDLE || depth_ff != 5'd0) begin
            e0 = mk(rsp_pkg::EV_PARSE_ERROR, 8'd0, 64'd0, depth_ff, 1'b0,
                    rsp_pkg::ERR_INCOMPLETE);
            cnt = 2'd1; fail_in = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_LINE; acc_in = '0; neg_in = 1'b0; seen_in = 1'b0;
               cr_in = 1'b0;
               unique case (in_byte)
                  rsp_pkg::ChPlus:   kind_in = LK_SIMPLE;
                  rsp_pkg::ChMinus:  kind_in = LK_ERROR;
                  rsp_pkg::ChColon:  kind_in = LK_INT;
                  rsp_pkg::ChDollar: kind_in = LK_BULK;
                  rsp_pkg::ChStar:   kind_in = LK_ARRAY;
                  default: begin
                     phase_in = PH_IDLE; acc_in = acc_ff; neg_in = neg_ff;
                     seen_in = seen_ff; cr_in = cr_ff;
                     e0 = mk(rsp_pkg::EV_PARSE_ERROR, 8'd0, 64'd0, depth_ff, 1'b0,
                             rsp_pkg::ERR_UNKNOWN);
                     cnt = 2'd1; fail_in = 1'b1;
                  end
               endcase
            end
            PH_LINE: begin
               if (cr_ff && in_byte == rsp_pkg::ChLf) begin
                  cr_in = 1'b0;
                  // Line end.
                  if (!seen_ff) begin
                     e0 = mk(rsp_pkg::EV_PARSE_ERROR, 8'd0, 64'd0, depth_ff, 1'b0,
                             (!is_str && neg_ff) ? rsp_pkg::ERR_BAD_NUMBER
                                                 : rsp_pkg::ERR_EMPTY);
                     cnt = 2'd1; fail_in = 1'b1;
                  end else if (is_str || kind_ff == LK_INT) begin
                     e0 = mk(kind_ff == LK_SIMPLE ? rsp_pkg::EV_SIMPLE_END :
                             kind_ff == LK_ERROR ? rsp_pkg::EV_ERROR_END :
                             rsp_pkg::EV_INTEGER, 8'd0,
                             (kind_ff == LK_INT) ? nval : 64'd0, depth_ff,
                             ~dec_any, rsp_pkg::ERR_NONE);
                     cnt = 2'd1; phase_in = PH_IDLE;
                  end else if (neg_ff && acc_ff != 64'd0) begin
                     if (acc_ff != 64'd1) begin
                        e0 = mk(rsp_pkg::EV_PARSE_ERROR, 8'd0, 64'd0, depth_ff, 1'b0,
                                rsp_pkg::ERR_BAD_NUMBER);
                        cnt = 2'd1; fail_in = 1'b1;
                     end else begin
                        e0 = mk(kind_ff == LK_BULK ? rsp_pkg::EV_BULK_NULL
                                                   : rsp_pkg::EV_ARRAY_NULL, 8'd0,
                                {64{1'b1}}, depth_ff, ~dec_any, rsp_pkg::ERR_NONE);
                        cnt = 2'd1; phase_in = PH_IDLE;
                     end
                  end else if (kind_ff == LK_BULK) begin
                     if (acc_ff > {34'd0, bulk_max}) begin
                        e0 = mk(rsp_pkg::EV_PARSE_ERROR, 8'd0, 64'd0, depth_ff, 1'b0,
                                rsp_pkg::ERR_BAD_NUMBER);
                        cnt = 2'd1; fail_in = 1'b1;
                     end else begin
                        bulk_in = acc_ff[29:0];
                        phase_in = (acc_ff[29:0] != 30'd0) ? PH_BULK : PH_BULK_CR;
                     end
                  end else begin
                     if (acc_ff > 64'h7FFFFFFF) begin
                        e0 = mk(rsp_pkg::EV_PARSE_ERROR, 8'd0, 64'd0, depth_ff, 1'b0,
                                rsp_pkg::ERR_BAD_NUMBER);
                        cnt = 2'd1; fail_in = 1'b1;
                     end else if (acc_ff == 64'd0) begin
                        e0 = mk(rsp_pkg::EV_ARRAY_HDR, 8'd0, 64'd0, depth_ff, ~dec_any,
                                rsp_pkg::ERR_NONE);
                        cnt = 2'd1; phase_in = PH_IDLE;
                     end else if (depth_ff >= limit) begin
                        e0 = mk(rsp_pkg::EV_PARSE_ERROR, 8'd0, 64'd0, depth_ff, 1'b0,
                                rsp_pkg::ERR_TOO_DEEP);
                        cnt = 2'd1; fail_in = 1'b1;
                     end else begin
                        e0 = mk(rsp_pkg::EV_ARRAY_HDR, 8'd0, acc_ff, depth_ff, 1'b0,
                                rsp_pkg::ERR_NONE);
                        cnt = 2'd1; phase_in = PH_IDLE;
                        lvl_we = 1'b1; lvl_widx = DW'(depth_ff);
                        lvl_wdata = acc_ff[31:0];
                        depth_in = depth_ff + 5'd1;
                     end
                  end
                  if (phase_in == PH_IDLE && !fail_in && !lvl_we) begin
                     // A value completed: count it against the open arrays.
                     depth_in = dec_depth;
                     if (dec_any) begin
                        lvl_we = 1'b1; lvl_widx = dec_idx;
                        lvl_wdata = lvl_ff[dec_idx] - 32'd1;
                     end
                  end
               end else begin
                  // Pending CR is data in a string line (a number line fails on it), then this byte (CR pends again).
                  logic pend_fail;
                  logic [63:0] a;
                  logic n, s;
                  pend_fail = 1'b0;
                  a = acc_ff; n = neg_ff; s = seen_ff;
                  cr_in = (in_byte == rsp_pkg::ChCr);
                  if (is_str) begin
                     if (cr_ff) begin
                        e0 = mk(kind_ff == LK_SIMPLE ? rsp_pkg::EV_SIMPLE_BYTE
                                                     : rsp_pkg::EV_ERROR_BYTE,
                                rsp_pkg::ChCr, 64'd0, depth_ff, 1'b0, rsp_pkg::ERR_NONE);
                        seen_in = 1'b1;
                     end
                     if (in_byte != rsp_pkg::ChCr) begin
                        if (cr_ff) begin
                           e1 = mk(e0.kind, dbyte, 64'd0, depth_ff, 1'b0,
                                   rsp_pkg::ERR_NONE);
                           cnt = 2'd2;
                        end else begin
                           e0 = mk(kind_ff == LK_SIMPLE ? rsp_pkg::EV_SIMPLE_BYTE
                                                        : rsp_pkg::EV_ERROR_BYTE,
                                   dbyte, 64'd0, depth_ff, 1'b0, rsp_pkg::ERR_NONE);
                           cnt = 2'd1;
                        end
                        seen_in = 1'b1;
                     end else begin
                        cnt = cr_ff ? 2'd1 : 2'd0;
                     end
                  end else begin
                     if (cr_ff) pend_fail = 1'b1;
                     else if (in_byte == rsp_pkg::ChCr) begin
                        a = acc_ff;
                     end else if (in_byte == rsp_pkg::ChMinus && !s && !n) begin
                        n = 1'b1;
                     end else if (is_digit && !ovf) begin
                        a = x10; s = 1'b1;
                     end else begin
                        pend_fail = 1'b1;
                     end
                     acc_in = a; neg_in = n; seen_in = s;
                     if (pend_fail) begin
                        e0 = mk(rsp_pkg::EV_PARSE_ERROR, 8'd0, 64'd0, depth_ff, 1'b0,
                                rsp_pkg::ERR_BAD_NUMBER);
                        cnt = 2'd1; fail_in = 1'b1; cr_in = 1'b0;
                     end
                  end
               end
            end
            PH_BULK: begin
               e0 = mk(rsp_pkg::EV_BULK_BYTE, dbyte, 64'd0, depth_ff, 1'b0,
                       rsp_pkg::ERR_NONE);
               cnt = 2'd1;
               bulk_in = bulk_ff - 30'd1;
               if (bulk_ff == 30'd1) phase_in = PH_BULK_CR;
            end
            PH_BULK_CR: begin
               if (in_byte == rsp_pkg::ChCr) phase_in = PH_BULK_LF;
               else begin
                  e0 = mk(rsp_pkg::EV_PARSE_ERROR, 8'd0, 64'd0, depth_ff, 1'b0,
                          rsp_pkg::ERR_NO_CRLF);
                  cnt = 2'd1; fail_in = 1'b1;
               end
            end
            PH_BULK_LF: begin
               if (in_byte == rsp_pkg::ChLf) begin
                  e0 = mk(rsp_pkg::EV_BULK_END, 8'd0, 64'd0, depth_ff, ~dec_any,
                          rsp_pkg::ERR_NONE);
                  cnt = 2'd1; phase_in = PH_IDLE;
                  depth_in = dec_depth;
                  if (dec_any) begin
                     lvl_we = 1'b1; lvl_widx = dec_idx;
                     lvl_wdata = lvl_ff[dec_idx] - 32'd1;
                  end
               end else begin
                  e0 = mk(rsp_pkg::EV_PARSE_ERROR, 8'd0, 64'd0, depth_ff, 1'b0,
                          rsp_pkg::ERR_NO_CRLF);
                  cnt = 2'd1; fail_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      if (lvl_we) more_in[lvl_widx] = (lvl_wdata != 32'd0);
      if (cnt == 2'd1) e0.last_of_run = 1'b1;
      if (cnt == 2'd2) e1.last_of_run = 1'b1;
   end

   assign ev_count = step ? cnt : 2'd0;
   assign ev0 = e0;
   assign ev1 = e1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; kind_ff <= LK_SIMPLE; acc_ff <= '0; neg_ff <= 1'b0;
         seen_ff <= 1'b0; cr_ff <= 1'b0; fail_ff <= 1'b0; bulk_ff <= '0;
         depth_ff <= '0; more_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; kind_ff <= kind_in; acc_ff <= acc_in; neg_ff <= neg_in;
         seen_ff <= seen_in; cr_ff <= cr_in; fail_ff <= fail_in; bulk_ff <= bulk_in;
         depth_ff <= depth_in; more_ff <= more_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && lvl_we && !restart) lvl_ff[lvl_widx] <= lvl_wdata;
   end

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= 5'(LimMax)) else $error("depth above limit");
   a_fail_silent: assert property (@(posedge clock) disable iff (reset)
      (fail_ff && !restart) |-> cnt == 2'd0) else $error("results after failure");
   a_two_only_str: assert property (@(posedge clock) disable iff (reset)
      cnt == 2'd2 |-> (phase_ff == PH_LINE && cr_ff)) else $error("bad pair");
`endif

endmodule

>>> rtl/rsp_queue.sv
module rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_count,
   input  rsp_pkg::event_type push0,
   input  rsp_pkg::event_type push1,
   output logic               has_room,
   input  logic               pop,
   output logic               not_empty,
   output rsp_pkg::event_type head
);

   localparam int Depth = 4;

   rsp_pkg::event_type slot_ff [Depth];
   logic [1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [2:0] cnt_ff, cnt_in;

   // Room for two results is kept so a front step never has to wait on count.
   assign has_room = (cnt_ff <= 3'd2);
   assign not_empty = (cnt_ff != 3'd0);
   assign head = slot_ff[rd_ff];

   always_comb begin
      rd_in = pop ? rd_ff + 2'd1 : rd_ff;
      wr_in = wr_ff + push_count;
      cnt_in = cnt_ff + {1'b0, push_count} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) slot_ff[wr_ff] <= push0;
      if (push_count == 2'd2) slot_ff[wr_ff + 2'd1] <= push1;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(Depth)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 3'd0) else $error("queue underflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |-> has_room) else $error("push without room");
`endif

endmodule

>>> rtl/resp_stream_parser_core.sv
// Channel  | direction | handshake              | payload
// req_     | in        | req_valid / req_stall  | in_byte, restart, end_of_data
// rsp_     | out       | rsp_valid / rsp_stall  | event fields, one per beat
// csr_     | in        | csr_write              | csr_index, csr_data
//
// The front parser takes one beat per cycle while req_stall is low and produces
// zero, one or two result beats in that same cycle; they enter a four-entry
// queue. req_stall rises only when the queue holds more than two beats, so input
// runs back to back while the output drains one beat per cycle when rsp_stall
// is low. Reset is synchronous; configuration returns to its reset values.
module resp_stream_parser_core #(
   parameter int MAX_DEPTH = rsp_pkg::MaxDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_restart,
   input  logic        req_end_of_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_event_kind,
   output logic [7:0]  rsp_data_byte,
   output logic signed [63:0] rsp_number,
   output logic [4:0]  rsp_nest_level,
   output logic        rsp_top_done,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_of_run,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [29:0] csr_data
);

   logic [29:0] bulk_max_ff;
   logic [4:0]  nest_max_ff;
   logic        step, room, pop, not_empty;
   logic [1:0]  ev_count;
   rsp_pkg::event_type ev0, ev1, head;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bulk_max_ff <= rsp_pkg::BulkMaxReset;
         nest_max_ff <= rsp_pkg::NestReset;
      end else if (csr_write) begin
         unique case (csr_index)
            rsp_pkg::CsrBulkMax: bulk_max_ff <= csr_data;
            rsp_pkg::CsrNest:    nest_max_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign req_stall = ~room;
   assign step = req_valid & room;

   rsp_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
      .clock(clock), .reset(reset), .step(step),
      .in_byte(req_in_byte), .restart(req_restart), .end_of_data(req_end_of_data),
      .bulk_max(bulk_max_ff), .nest_max(nest_max_ff),
      .ev_count(ev_count), .ev0(ev0), .ev1(ev1)
   );

   assign pop = not_empty & ~rsp_stall;

   rsp_queue u_queue (
      .clock(clock), .reset(reset), .push_count(ev_count), .push0(ev0), .push1(ev1),
      .has_room(room), .pop(pop), .not_empty(not_empty), .head(head)
   );

   assign rsp_valid       = not_empty;
   assign rsp_event_kind  = head.kind;
   assign rsp_data_byte   = head.data_byte;
   assign rsp_number      = head.number;
   assign rsp_nest_level  = head.nest_level;
   assign rsp_top_done    = head.top_done;
   assign rsp_error_code  = head.error_code;
   assign rsp_last_of_run = head.last_of_run;

`ifndef SYNTHESIS
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> not_empty) else $error("stall with empty queue");
   a_valid_from_queue: assert property (@(posedge clock) disable iff (reset)
      (ev_count != 2'd0 && !pop) |=> rsp_valid) else $error("result lost");
   a_csr_nest: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == rsp_pkg::CsrNest) |=> nest_max_ff == $past(csr_data[4:0]))
      else $error("config write lost");
`endif

endmodule

>>> test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // One input beat: a stream byte, or a restart, or an end-of-buffer marker.
   typedef struct {
      logic [7:0] value;
      bit         restart;
      bit         eod;
   } stream_beat_type;

   // Running model of the parser. It holds its own copy of the parse state and of
   // both configuration registers, turns each accepted input beat into the events
   // it should cause, and matches those events against the output in order.
   class parse_scoreboard;
      typedef enum {P_IDLE, P_LINE, P_BULK_DATA, P_BULK_CR, P_BULK_LF} sb_phase_type;
      typedef enum {L_SIMPLE, L_ERROR, L_INT, L_BULK, L_ARRAY} sb_line_type;

      logic [29:0] bulk_max;
      logic [4:0]  nest_max;
      sb_phase_type phase;
      sb_line_type  lkind;
      logic [63:0] acc;
      bit          neg, seen, cr_held, failed;
      logic [29:0] bulk_left;
      logic [31:0] level_left[rsp_pkg::MaxDepthDefault];
      int          depth;
      rsp_pkg::event_type run[$];
      rsp_pkg::event_type pending[$];
      int          errors;

      function new();
         bulk_max = rsp_pkg::BulkMaxReset;
         nest_max = rsp_pkg::NestReset;
         errors = 0;
         clear();
      endfunction

      function void clear();
         phase = P_IDLE;
         lkind = L_SIMPLE;
         acc = '0;
         neg = 0;
         seen = 0;
         cr_held = 0;
         failed = 0;
         bulk_left = '0;
         foreach (level_left[i]) level_left[i] = '0;
         depth = 0;
      endfunction

      function void emit(rsp_pkg::event_kind_type k, logic [7:0] b, logic [63:0] n,
                         int lvl, bit top, rsp_pkg::error_code_type e);
         rsp_pkg::event_type ev;
         if (run.size() >= 2) return;
         ev.kind = k;
         ev.data_byte = b;
         ev.number = n;
         ev.nest_level = lvl[4:0];
         ev.top_done = top;
         ev.error_code = e;
         ev.last_of_run = 1'b0;
         run.insert(run.size(), ev);
      endfunction

      function void fail(rsp_pkg::error_code_type e);
         emit(rsp_pkg::EV_PARSE_ERROR, 8'h00, 64'd0, depth, 1'b0, e);
         failed = 1;
      endfunction

      function int depth_cap();
         int lim;
         lim = nest_max;
         if (lim < 1) lim = 1;
         if (lim > rsp_pkg::MaxDepthDefault) lim = rsp_pkg::MaxDepthDefault;
         if (lim > 31) lim = 31;
         return lim;
      endfunction

      // Counts one finished element against the open arrays. Returns 1 when that
      // element closes the whole top-level value.
      function bit pop_levels();
         while (depth > 0) begin
            if (level_left[depth-1] > 0) level_left[depth-1]--;
            if (level_left[depth-1] != 0) return 0;
            depth--;
         end
         return 1;
      endfunction

      function void finish(rsp_pkg::event_kind_type k, logic [63:0] n);
         int lvl;
         bit top;
         lvl = depth;
         top = pop_levels();
         emit(k, 8'h00, n, lvl, top, rsp_pkg::ERR_NONE);
         phase = P_IDLE;
      endfunction

      function void line_data(logic [7:0] b);
         logic [63:0] d, lim;
         if (lkind == L_SIMPLE || lkind == L_ERROR) begin
            seen = 1;
            emit(lkind == L_SIMPLE ? rsp_pkg::EV_SIMPLE_BYTE : rsp_pkg::EV_ERROR_BYTE,
                 b, 64'd0, depth, 1'b0, rsp_pkg::ERR_NONE);
            return;
         end
         if (b == rsp_pkg::ChMinus && !seen && !neg) begin
            neg = 1;
            return;
         end
         if (b >= 8'h30 && b <= 8'h39) begin
            d = 64'(b - 8'h30);
            lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            if (acc > (lim - d) / 10) begin
               fail(rsp_pkg::ERR_BAD_NUMBER);
            end else begin
               acc = acc * 10 + d;
               seen = 1;
            end
            return;
         end
         fail(rsp_pkg::ERR_BAD_NUMBER);
      endfunction

      function void line_end();
         if (lkind == L_SIMPLE || lkind == L_ERROR) begin
            if (!seen) fail(rsp_pkg::ERR_EMPTY);
            else finish(lkind == L_SIMPLE ? rsp_pkg::EV_SIMPLE_END
                                          : rsp_pkg::EV_ERROR_END, 64'd0);
            return;
         end
         if (!seen) begin
            fail(neg ? rsp_pkg::ERR_BAD_NUMBER : rsp_pkg::ERR_EMPTY);
            return;
         end
         if (lkind == L_INT) begin
            finish(rsp_pkg::EV_INTEGER, neg ? -acc : acc);
            return;
         end
         // Only minus one is a legal negative length or count: it means null.
         if (neg && acc != 0) begin
            if (acc != 1) fail(rsp_pkg::ERR_BAD_NUMBER);
            else finish(lkind == L_BULK ? rsp_pkg::EV_BULK_NULL
                                        : rsp_pkg::EV_ARRAY_NULL, '1);
            return;
         end
         if (lkind == L_BULK) begin
            if (acc > 64'(bulk_max)) begin
               fail(rsp_pkg::ERR_BAD_NUMBER);
               return;
            end
            bulk_left = acc[29:0];
            phase = (bulk_left != 0) ? P_BULK_DATA : P_BULK_CR;
            return;
         end
         if (acc > 64'h7fff_ffff) begin
            fail(rsp_pkg::ERR_BAD_NUMBER);
            return;
         end
         if (acc == 0) begin
            finish(rsp_pkg::EV_ARRAY_HDR, 64'd0);
            return;
         end
         if (depth >= depth_cap()) begin
            fail(rsp_pkg::ERR_TOO_DEEP);
            return;
         end
         emit(rsp_pkg::EV_ARRAY_HDR, 8'h00, acc, depth, 1'b0, rsp_pkg::ERR_NONE);
         level_left[depth] = acc[31:0];
         depth++;
         phase = P_IDLE;
      endfunction

      function void start_value(logic [7:0] b);
         case (b)
            rsp_pkg::ChPlus:   lkind = L_SIMPLE;
            rsp_pkg::ChMinus:  lkind = L_ERROR;
            rsp_pkg::ChColon:  lkind = L_INT;
            rsp_pkg::ChDollar: lkind = L_BULK;
            rsp_pkg::ChStar:   lkind = L_ARRAY;
            default: begin
               fail(rsp_pkg::ERR_UNKNOWN);
               return;
            end
         endcase
         acc = '0;
         neg = 0;
         seen = 0;
         cr_held = 0;
         phase = P_LINE;
      endfunction

      // A CR is held back until the next byte shows whether it ends the line.
      function void line_byte(logic [7:0] b);
         if (cr_held) begin
            cr_held = 0;
            if (b == rsp_pkg::ChLf) begin
               line_end();
               return;
            end
            line_data(rsp_pkg::ChCr);
            if (failed) return;
         end
         if (b == rsp_pkg::ChCr) cr_held = 1;
         else line_data(b);
      endfunction

      function void note_beat(stream_beat_type s);
         run.delete();
         if (s.restart) begin
            clear();
            return;
         end
         if (failed) return;
         if (s.eod) begin
            if (phase != P_IDLE || depth != 0) fail(rsp_pkg::ERR_INCOMPLETE);
         end else begin
            case (phase)
               P_IDLE: start_value(s.value);
               P_LINE: line_byte(s.value);
               P_BULK_DATA: begin
                  emit(rsp_pkg::EV_BULK_BYTE, s.value, 64'd0, depth, 1'b0,
                       rsp_pkg::ERR_NONE);
                  if (bulk_left > 0) bulk_left--;
                  if (bulk_left == 0) phase = P_BULK_CR;
               end
               P_BULK_CR: begin
                  if (s.value == rsp_pkg::ChCr) phase = P_BULK_LF;
                  else fail(rsp_pkg::ERR_NO_CRLF);
               end
               P_BULK_LF: begin
                  if (s.value == rsp_pkg::ChLf) finish(rsp_pkg::EV_BULK_END, 64'd0);
                  else fail(rsp_pkg::ERR_NO_CRLF);
               end
            endcase
         end
         if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
         foreach (run[i]) pending.insert(pending.size(), run[i]);
      endfunction

      function void same(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_event(rsp_pkg::event_type got);
         rsp_pkg::event_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected event, kind %0d", $time, got.kind);
            errors++;
            return;
         end
         want = pending.pop_front();
         same("event_kind", 64'(want.kind), 64'(got.kind));
         same("data_byte", 64'(want.data_byte), 64'(got.data_byte));
         same("number", want.number, got.number);
         same("nest_level", 64'(want.nest_level), 64'(got.nest_level));
         same("top_done", 64'(want.top_done), 64'(got.top_done));
         same("error_code", 64'(want.error_code), 64'(got.error_code));
         same("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall, req_restart, req_end_of_data;
   logic [7:0] req_in_byte;
   logic rsp_valid, rsp_stall;
   logic [3:0] rsp_event_kind;
   logic [7:0] rsp_data_byte;
   logic signed [63:0] rsp_number;
   logic [4:0] rsp_nest_level;
   logic rsp_top_done, rsp_last_of_run;
   logic [2:0] rsp_error_code;
   logic csr_write, csr_index;
   logic [29:0] csr_data;

   parse_scoreboard sb;
   stream_beat_type beats[$];
   int              send_idle_pct, recv_idle_pct;
   int              quiet_cycles;

   resp_stream_parser_core DUT (.*);

   always #6 clock = ~clock;

   // The receiver checks every accepted result beat and then decides, at random,
   // whether to stall during the next cycle.
   always @(posedge clock) begin
      rsp_pkg::event_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.kind = rsp_pkg::event_kind_type'(rsp_event_kind);
            got.data_byte = rsp_data_byte;
            got.number = rsp_number;
            got.nest_level = rsp_nest_level;
            got.top_done = rsp_top_done;
            got.error_code = rsp_pkg::error_code_type'(rsp_error_code);
            got.last_of_run = rsp_last_of_run;
            sb.check_event(got);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // The watchdog trips when neither channel has moved a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles > 4000) begin
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_byte(logic [7:0] b);
      stream_beat_type s;
      s.value = b;
      s.restart = 0;
      s.eod = 0;
      beats.insert(beats.size(), s);
   endtask

   task automatic push_marker(bit restart);
      stream_beat_type s;
      s.value = 8'($urandom_range(255));
      s.restart = restart;
      s.eod = !restart || ($urandom_range(1) == 1);
      beats.insert(beats.size(), s);
   endtask

   task automatic push_text(string t);
      for (int i = 0; i < t.len(); i++) push_byte(t[i]);
   endtask

   task automatic push_crlf();
      push_byte(rsp_pkg::ChCr);
      push_byte(rsp_pkg::ChLf);
   endtask

   // Appends one random value. Mostly well formed, with a share of broken numbers,
   // lone CR and LF bytes, bad trailers and unknown type bytes.
   task automatic gen_value(int lvl);
      int r, n;
      longint len;
      string t;
      r = $urandom_range(99);
      if (r < 4) begin
         push_byte(8'($urandom_range(255)));
      end else if (r < 30) begin
         push_byte(r < 18 ? rsp_pkg::ChPlus : rsp_pkg::ChMinus);
         n = $urandom_range(0, 6);
         repeat (n) begin
            case ($urandom_range(9))
               0: push_byte(rsp_pkg::ChCr);
               1: push_byte(rsp_pkg::ChLf);
               default: push_byte(8'($urandom_range(255)));
            endcase
         end
         push_crlf();
      end else if (r < 48) begin
         push_byte(rsp_pkg::ChColon);
         case ($urandom_range(11))
            0: t = $sformatf("%0d", int'($urandom()));
            1: t = "9223372036854775807";
            2: t = "-9223372036854775808";
            3: t = "9223372036854775808";
            4: t = "-9223372036854775809";
            5: t = "-0";
            6: t = "";
            7: t = "-";
            8: t = $urandom_range(1) ? "1x" : "1\r2";
            default: t = $sformatf("%0d", $urandom_range(0, 999));
         endcase
         push_text(t);
         push_crlf();
      end else if (r < 72) begin
         push_byte(rsp_pkg::ChDollar);
         case ($urandom_range(11))
            8:  len = -1;
            9:  len = -2;
            10: len = (sb.bulk_max <= 8) ? longint'(sb.bulk_max) : longint'(sb.bulk_max) + 1;
            11: len = longint'(sb.bulk_max) + 1;
            default: len = $urandom_range(0, 6);
         endcase
         push_text($sformatf("%0d", len));
         push_crlf();
         if (len > 0 && len <= 8) repeat (int'(len)) push_byte(8'($urandom_range(255)));
         if ($urandom_range(9) == 0) begin
            push_byte(8'($urandom_range(255)));
            push_byte(8'($urandom_range(255)));
         end else begin
            push_crlf();
         end
      end else begin
         push_byte(rsp_pkg::ChStar);
         r = $urandom_range(99);
         if (r < 8) begin
            push_text("-1");
            n = 0;
         end else if (r < 11) begin
            push_text($urandom_range(1) ? "-3" : "2147483648");
            n = 0;
         end else begin
            n = (lvl < 3) ? $urandom_range(0, 3) : $urandom_range(0, 1);
            push_text($sformatf("%0d", n));
         end
         push_crlf();
         if (lvl < 6) repeat (n) gen_value(lvl + 1);
      end
   endtask

   // A message usually opens with a restart so that a parse error does not
   // silence the rest of the stream. Some messages nest deep on purpose, some
   // stop early with an end-of-buffer marker.
   task automatic gen_message();
      int k;
      if ($urandom_range(99) < 85) push_marker(1);
      if ($urandom_range(99) < 6) begin
         k = $urandom_range(1, 17);
         repeat (k) begin
            push_text("*1");
            push_crlf();
         end
         gen_value(k);
      end else begin
         gen_value(0);
      end
      if ($urandom_range(99) < 6) begin
         k = $urandom_range(1, 4);
         repeat (k) if (beats.size() > 1) void'(beats.pop_back());
         push_marker(0);
      end else if ($urandom_range(99) < 10) begin
         push_marker(0);
      end
   endtask

   task automatic send_beat(stream_beat_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= s.value;
      req_restart <= s.restart;
      req_end_of_data <= s.eod;
      do @(posedge clock); while (req_stall);
      sb.note_beat(s);
   endtask

   // Drains every expected event, then idles so that beats that cause nothing
   // clear the pipeline.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [29:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      if (index == rsp_pkg::CsrBulkMax) sb.bulk_max = value;
      else sb.nest_max = value[4:0];
   endtask

   task automatic send_all();
      int half;
      half = beats.size() / 2;
      for (int i = 0; i < beats.size(); i++) begin
         if (i == half) drain();
         send_beat(beats[i]);
      end
      beats.delete();
   endtask

   initial begin
      logic [29:0] bulk_set[6];
      logic [4:0]  nest_set[6];
      bulk_set = '{rsp_pkg::BulkMaxReset, 30'd0, 30'd7, 30'h3fff_ffff, 30'd3,
                   rsp_pkg::BulkMaxReset};
      nest_set = '{rsp_pkg::NestReset, 5'd1, 5'd3, 5'd31, 5'd0, 5'd2};
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_in_byte <= 8'h00;
      req_restart <= 1'b0;
      req_end_of_data <= 1'b0;
      rsp_stall <= 1'b0;
      csr_write <= 1'b0;
      csr_index <= rsp_pkg::CsrBulkMax;
      csr_data <= '0;
      send_idle_pct = 7;
      recv_idle_pct = 47;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int set = 0; set < 6; set++) begin
         if (set == 2) begin
            send_idle_pct = 47;
            recv_idle_pct = 7;
         end else if (set == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain();
         write_csr(rsp_pkg::CsrBulkMax, bulk_set[set]);
         write_csr(rsp_pkg::CsrNest, {25'd0, nest_set[set]});
         csr_write <= 1'b0;

         if (set == 0) begin
            // Restart together with an end marker, then an end marker while idle.
            push_marker(1);
            beats[0].eod = 1;
            push_marker(0);
            // A lone CR inside a simple string is a data byte.
            push_text("+a\rb");
            push_crlf();
            // A bulk payload followed by something other than CR LF.
            push_text("$1");
            push_crlf();
            push_text("xy");
            push_marker(1);
            push_text(":-0");
            push_crlf();
            // Unknown type byte.
            push_byte(8'h21);
            push_marker(1);
            send_all();
         end

         while (beats.size() < 230) gen_message();
         send_all();
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/rsp_pkg.sv
rtl/rsp_front.sv
rtl/rsp_queue.sv
rtl/resp_stream_parser_core.sv
test/tb_top.sv
